// ===== rtl/core/lvq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvq_pkg: shared types and codes for the two-prototype LVQ trainer
// Holds the request payload types, the action, update-kind and config codes
// and the accumulator width used by the front end.
// ----------------------------------------------------------------------------
package lvq_pkg;

    localparam logic ACT_ELEM    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    localparam logic [1:0] KIND_STORE  = 2'd0;
    localparam logic [1:0] KIND_TOWARD = 2'd1;
    localparam logic [1:0] KIND_AWAY   = 2'd2;
    localparam logic [1:0] KIND_TIE    = 2'd3;

    localparam logic CFG_DIM  = 1'b0;
    localparam logic CFG_RATE = 1'b1;

    localparam int ACC_W = 40;

    typedef struct packed {
        logic               action;
        logic signed [15:0] elem_value;
        logic [7:0]         class_label;
    } in_req_t;

    typedef struct packed {
        logic               proto_index;
        logic [3:0]         element_index;
        logic signed [15:0] proto_value;
        logic [1:0]         update_kind;
        logic               saturated;
        logic               last_of_run;
    } out_req_t;

endpackage

// ===== rtl/core/lvq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvq_in_if / lvq_out_if: valid-ready channels
// One request moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface lvq_in_if;
    logic             valid;
    logic             ready;
    lvq_pkg::in_req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lvq_out_if;
    logic              valid;
    logic              ready;
    lvq_pkg::out_req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/lvq_two_prototype_trainer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvq_two_prototype_trainer: LVQ1 training with two prototypes
// Elements stream in; the first two vectors seed the prototypes, after that
// the nearer prototype is updated (kept on a tie); its elements are emitted.
// ----------------------------------------------------------------------------
// channel  dir  payload
// req_in   in   action, elem_value, class_label
// res_out  out  proto_index, element_index, proto_value, update_kind,
//               saturated, last_of_run
// cfg      in   cfg_we, cfg_index, cfg_data (dim, learning_rate)
//
// An element is accepted, then its distance is accumulated.
// A completed vector is handed over as a job; the back end then steps each
// element through RAM read, product, update and write-back, and output
// hand-off, as the RAM read and the product are both registered.
// Output stalls hold the back end; the front end stops taking requests
// while the back end is busy. Reset clears control state and the distance
// sums; the stores are undefined until written.
// ----------------------------------------------------------------------------
module lvq_two_prototype_trainer #(
    parameter int DIM = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    lvq_in_if.sink      req_in,
    lvq_out_if.source   res_out,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import lvq_pkg::*;

    localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;

    logic [4:0]   dim_reg;
    logic [15:0]  rate_reg;
    logic [AW:0]  eff_dim;
    logic [AW-1:0] pr_addr, vb_addr;
    logic signed [15:0] p0_rd, p1_rd;
    logic         vb_we;
    logic [15:0]  vb_data;
    logic         job_valid, job_ready, job_proto, busy;
    logic [1:0]   job_kind;
    logic [7:0]   job_label;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg  <= 5'd16;
            rate_reg <= 16'd3277;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_DIM)
            begin
                dim_reg <= cfg_data[4:0];
            end
            else
            begin
                rate_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        if (dim_reg == 5'd0)
        begin
            eff_dim = (AW+1)'(1);
        end
        else if (32'(dim_reg) > DIM)
        begin
            eff_dim = (AW+1)'(DIM);
        end
        else
        begin
            eff_dim = (AW+1)'(dim_reg);
        end
    end

    lvq_front #(.DIM(DIM), .AW(AW)) u_front (
        .clk(clk), .rst_n(rst_n), .req_in(req_in), .eff_dim(eff_dim),
        .pr_addr(pr_addr), .pr0_data(p0_rd), .pr1_data(p1_rd),
        .vb_we(vb_we), .vb_addr(vb_addr), .vb_data(vb_data),
        .job_valid(job_valid), .job_ready(job_ready), .job_proto(job_proto),
        .job_kind(job_kind), .job_label(job_label), .busy(busy));

    lvq_back #(.DIM(DIM), .AW(AW)) u_back (
        .clk(clk), .rst_n(rst_n), .eff_dim(eff_dim), .rate(rate_reg),
        .job_valid(job_valid), .job_ready(job_ready), .job_proto(job_proto),
        .job_kind(job_kind), .job_label(job_label), .busy(busy),
        .fr_addr(pr_addr), .p0_rd(p0_rd), .p1_rd(p1_rd),
        .vb_we(vb_we), .vb_waddr(vb_addr), .vb_wdata(vb_data),
        .res_out(res_out));
endmodule

// ===== rtl/core/lvq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvq_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lvq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/lvq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvq_front: element intake and distance accumulation
// Buffers elements, sums squared distances to both prototypes and hands a
// finished vector to the update engine as a job (stored, decided or tie).
// ----------------------------------------------------------------------------
module lvq_front #(
    parameter int DIM = 16,
    parameter int AW  = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    lvq_in_if.sink                 req_in,
    input  logic [AW:0]            eff_dim,
    // prototype read port (two words per cycle, shared with back end)
    output logic [AW-1:0]          pr_addr,
    input  logic signed [15:0]     pr0_data,
    input  logic signed [15:0]     pr1_data,
    // vector buffer write
    output logic                   vb_we,
    output logic [AW-1:0]          vb_addr,
    output logic [15:0]            vb_data,
    // job handoff
    output logic                   job_valid,
    input  logic                   job_ready,
    output logic                   job_proto,
    output logic [1:0]             job_kind,
    output logic [7:0]             job_label,
    input  logic                   busy
);
    import lvq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_JOB  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [AW:0]         count_reg;
    logic [1:0]          seen_reg;
    logic [ACC_W-1:0]    d0_reg, d1_reg;
    logic signed [15:0]  x_reg;
    logic                last_reg;
    logic [7:0]          label_reg;
    logic [AW-1:0]       idx;
    logic [AW:0]         idx_w;
    logic signed [16:0]  df0, df1;
    logic [ACC_W-1:0]    d0_sum, d1_sum;
    logic [1:0]          kind_sel;
    logic                proto_sel;

    assign idx_w   = (count_reg >= (AW+1)'(DIM)) ? (AW+1)'(DIM - 1) : count_reg;
    assign idx     = idx_w[AW-1:0];
    assign req_in.ready = (state_reg == ST_IDLE) && !busy;
    assign pr_addr = idx;
    assign vb_we   = req_in.valid && req_in.ready && (req_in.data.action == ACT_ELEM);
    assign vb_addr = idx;
    assign vb_data = req_in.data.elem_value;

    assign df0    = 17'(x_reg) - 17'(pr0_data);
    assign df1    = 17'(x_reg) - 17'(pr1_data);
    assign d0_sum = d0_reg + ACC_W'(unsigned'(34'(df0 * df0)));
    assign d1_sum = d1_reg + ACC_W'(unsigned'(34'(df1 * df1)));

    always_comb
    begin
        if (seen_reg < 2'd2)
        begin
            proto_sel = seen_reg[0];
            kind_sel  = KIND_STORE;
        end
        else if (d0_reg == d1_reg)
        begin
            proto_sel = 1'b0;
            kind_sel  = KIND_TIE;
        end
        else
        begin
            proto_sel = !(d0_reg < d1_reg);
            kind_sel  = KIND_TOWARD;
        end
    end
    assign job_valid = (state_reg == ST_JOB);
    assign job_proto = proto_sel;
    assign job_kind  = kind_sel;
    assign job_label = label_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (req_in.valid && req_in.ready && req_in.data.action == ACT_ELEM)
                begin
                    state_next = ST_ACC;
                end
            ST_ACC:  state_next = last_reg ? ST_JOB : ST_IDLE;
            ST_JOB:  if (job_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            seen_reg  <= '0;
            d0_reg    <= '0;
            d1_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_in.valid && req_in.ready)
            begin
                if (req_in.data.action == ACT_RESTART)
                begin
                    count_reg <= '0;
                    seen_reg  <= '0;
                    d0_reg    <= '0;
                    d1_reg    <= '0;
                end
                else
                begin
                    count_reg <= (idx_w + 1'b1 < eff_dim) ? idx_w + 1'b1 : '0;
                end
            end
            if (state_reg == ST_ACC && seen_reg == 2'd2)
            begin
                d0_reg <= d0_sum;
                d1_reg <= d1_sum;
            end
            if (state_reg == ST_JOB && job_ready)
            begin
                d0_reg <= '0;
                d1_reg <= '0;
                if (seen_reg < 2'd2)
                begin
                    seen_reg <= seen_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_in.valid && req_in.ready)
        begin
            x_reg     <= req_in.data.elem_value;
            last_reg  <= !(idx_w + 1'b1 < eff_dim);
            label_reg <= req_in.data.class_label;
        end
    end
endmodule

// ===== rtl/core/lvq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvq_back: prototype store and update engine
// Takes a job, walks the prototype element by element, writes the vector
// or the saturated LVQ1 step (none on a tie); emits a request per element.
// ----------------------------------------------------------------------------
module lvq_back #(
    parameter int DIM = 16,
    parameter int AW  = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [AW:0]        eff_dim,
    input  logic [15:0]        rate,
    input  logic               job_valid,
    output logic               job_ready,
    input  logic               job_proto,
    input  logic [1:0]         job_kind,
    input  logic [7:0]         job_label,
    output logic               busy,
    input  logic [AW-1:0]      fr_addr,
    output logic signed [15:0] p0_rd,
    output logic signed [15:0] p1_rd,
    input  logic               vb_we,
    input  logic [AW-1:0]      vb_waddr,
    input  logic [15:0]        vb_wdata,
    lvq_out_if.source          res_out
);
    import lvq_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [AW:0]          i_reg;
    logic                 proto_reg;
    logic [1:0]           kind_reg;
    logic [7:0]           cls_reg [2];
    logic signed [33:0]   prod_reg;
    logic signed [15:0]   pv_reg;
    logic [15:0]          xv_reg;
    logic [AW-1:0]        raddr;
    logic [AW:0]          paddr_w;
    logic                 pwe;
    logic [15:0]          pwdata;
    logic [15:0]          p_rd0, p_rd1, vb_rd;
    logic signed [16:0]   rate_s;
    logic signed [16:0]   diff;
    logic signed [33:0]   stp;
    logic signed [18:0]   nv;
    logic signed [15:0]   nv_sat;
    logic                 sat;
    logic signed [15:0]   pv_cur;
    logic                 ovalid_reg;
    out_req_t             odata_reg;

    assign raddr = (state_reg == ST_IDLE) ? fr_addr : i_reg[AW-1:0];
    lvq_ram #(.WIDTH(16), .DEPTH(DIM)) u_p0 (.clk(clk),
        .we(pwe && !proto_reg), .waddr(i_reg[AW-1:0]), .wdata(pwdata),
        .raddr(raddr), .rdata(p_rd0));
    lvq_ram #(.WIDTH(16), .DEPTH(DIM)) u_p1 (.clk(clk),
        .we(pwe && proto_reg), .waddr(i_reg[AW-1:0]), .wdata(pwdata),
        .raddr(raddr), .rdata(p_rd1));
    lvq_ram #(.WIDTH(16), .DEPTH(DIM)) u_vb (.clk(clk),
        .we(vb_we), .waddr(vb_waddr), .wdata(vb_wdata),
        .raddr(raddr), .rdata(vb_rd));
    assign paddr_w = i_reg;
    assign p0_rd = p_rd0;
    assign p1_rd = p_rd1;

    assign busy      = (state_reg != ST_IDLE) || ovalid_reg;
    assign job_ready = (state_reg == ST_IDLE) && !ovalid_reg;

    assign rate_s = signed'({1'b0, rate});
    assign pv_cur = proto_reg ? signed'(p_rd1) : signed'(p_rd0);
    assign diff   = 17'(signed'(vb_rd)) - 17'(pv_cur);
    assign stp    = (prod_reg + 34'sd32768) >>> 16;
    assign nv     = (kind_reg == KIND_TOWARD) ? 19'(pv_reg) + 19'(stp)
                                              : 19'(pv_reg) - 19'(stp);
    always_comb
    begin
        sat = 1'b0;
        nv_sat = nv[15:0];
        if (nv > 19'sd32767)
        begin
            nv_sat = 16'sh7fff;
            sat = 1'b1;
        end
        else if (nv < -19'sd32768)
        begin
            nv_sat = 16'sh8000;
            sat = 1'b1;
        end
    end
    always_comb
    begin
        pwe = 1'b0;
        pwdata = nv_sat;
        if (state_reg == ST_UPD)
        begin
            if (kind_reg == KIND_STORE)
            begin
                pwe = 1'b1;
                pwdata = xv_reg;
            end
            else if (kind_reg != KIND_TIE)
            begin
                pwe = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (job_valid && job_ready) state_next = ST_RD;
            ST_RD:   state_next = ST_MUL;
            ST_MUL:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_OUT;
            ST_OUT:
                if (!ovalid_reg || res_out.ready)
                begin
                    state_next = (paddr_w + 1'b1 < eff_dim) ? ST_RD : ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            i_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_out.valid && res_out.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE)
            begin
                i_reg <= '0;
            end
            if (state_reg == ST_UPD)
            begin
                ovalid_reg <= 1'b1;
            end
            if (state_reg == ST_OUT && (!ovalid_reg || res_out.ready))
            begin
                i_reg <= i_reg + 1'b1;
            end
        end
    end

    // ST_OUT waits for the slot to drain; the new request is loaded in ST_UPD
    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            proto_reg <= job_proto;
            if (job_kind == KIND_STORE)
            begin
                kind_reg <= KIND_STORE;
                cls_reg[job_proto] <= job_label;
            end
            else if (job_kind == KIND_TIE)
            begin
                kind_reg <= KIND_TIE;
            end
            else
            begin
                kind_reg <= (cls_reg[job_proto] == job_label) ? KIND_TOWARD : KIND_AWAY;
            end
        end
        if (state_reg == ST_UPD)
        begin
            odata_reg.proto_index   <= proto_reg;
            odata_reg.element_index <= 4'(i_reg);
            odata_reg.update_kind   <= kind_reg;
            odata_reg.last_of_run   <= !(paddr_w + 1'b1 < eff_dim);
            if (kind_reg == KIND_STORE)
            begin
                odata_reg.proto_value <= signed'(xv_reg);
                odata_reg.saturated   <= 1'b0;
            end
            else if (kind_reg == KIND_TIE)
            begin
                odata_reg.proto_value <= pv_reg;
                odata_reg.saturated   <= 1'b0;
            end
            else
            begin
                odata_reg.proto_value <= nv_sat;
                odata_reg.saturated   <= sat;
            end
        end
    end

    // product stage: RAM data read in ST_RD arrives in ST_MUL; the product
    // and both operands are registered for the update in ST_UPD
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_reg <= rate_s * diff;
            pv_reg   <= pv_cur;
            xv_reg   <= vb_rd;
        end
    end

    assign res_out.valid = ovalid_reg;
    assign res_out.data  = odata_reg;
endmodule

// ===== rtl/core/lvq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvq_checker: port-level checks for the LVQ trainer
// ----------------------------------------------------------------------------
module lvq_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] out_kind,
    input logic out_sat
);
    import lvq_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_STORE || out_kind == KIND_TIE) |-> !out_sat)
        else $error("saturation on unchanged element");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("intake open during emit");
endmodule

bind lvq_two_prototype_trainer lvq_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(req_in.valid), .in_ready(req_in.ready),
    .out_valid(res_out.valid), .out_ready(res_out.ready),
    .out_kind(res_out.data.update_kind), .out_sat(res_out.data.saturated));
